// ===== sv/palette_ripple_blender_top_assert.svh =====
// Assertion macros used by the palette ripple blender controller.
`ifndef PALETTE_RIPPLE_BLENDER_TOP_ASSERT_SVH
`define PALETTE_RIPPLE_BLENDER_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prb assertion failed in the same cycle");

// Consequence must hold in the cycle after the antecedent.
`define PRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prb assertion failed in the next cycle");

`endif

// ===== sv/prb_pkg.sv =====
// Package with constants, codes and interface structs of the palette ripple blender.
`timescale 1ns / 1ps

package prb_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
   localparam int WINDOW_CAP    = (PALETTE_DEPTH < 254) ? PALETTE_DEPTH : 254;
   localparam int POS_QBITS     = 10;
   localparam int LANE_QBITS    = 8;
   localparam int CNT_W         = $clog2(POS_QBITS + 1);

   localparam logic [1:0] CSR_PULSE_FRAMES = 2'd0;
   localparam logic [1:0] CSR_RIPPLE_WIDTH = 2'd1;
   localparam logic [1:0] CSR_PALETTE_SIZE = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_START = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUT_ZERO   = 2'd0,
      OUT_READ   = 2'd1,
      OUT_ACTIVE = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mem_write;
      logic        mem_read;
      logic        start_apply;
      logic        frame_clear;
      logic        frame_adv;
      logic        pos_mul;
      logic        pos_load;
      logic        pos_step;
      logic        win_setup;
      logic        ent_read;
      logic        ent_skip;
      logic        lane_load;
      logic        lane_step;
      logic        ent_write;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   frame_idle;
      logic   frame_last;
      logic   pos_over;
      logic   walk_done;
      logic   ent_skip;
   } sts_type;

endpackage

// ===== sv/prb_lane.sv =====
// One colour channel divider: restoring division, one quotient bit per step.
`timescale 1ns / 1ps

module prb_lane (
   input  logic        clock,
   input  logic        load,
   input  logic        step,
   input  logic [14:0] num,
   input  logic [7:0]  den,
   output logic [7:0]  quot
);

   logic [7:0] rem_ff, rem_in;
   logic [7:0] sh_ff, sh_in;
   logic [7:0] den_ff;
   logic [8:0] trial;
   logic       fits;

   // The quotient never exceeds 255, so the top bits start below the divisor.
   assign trial = {rem_ff, sh_ff[7]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      if (load) begin
         rem_in = {1'b0, num[14:8]};
         sh_in  = num[7:0];
      end else if (step) begin
         rem_in = fits ? 8'(trial - {1'b0, den_ff}) : trial[7:0];
         sh_in  = {sh_ff[6:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      if (load) begin
         den_ff <= den;
      end
   end

   assign quot = sh_ff;

endmodule

// ===== sv/prb_datapath.sv =====
// Datapath: configuration, palette memory, position divider, channel dividers, result register.
`timescale 1ns / 1ps

module prb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  prb_pkg::cmd_type    cmd,
   output prb_pkg::sts_type    sts,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [11:0]         csr_wdata,
   input  logic [1:0]          req_operation,
   input  logic [7:0]          req_entry_index,
   input  logic [7:0]          req_red_in,
   input  logic [7:0]          req_green_in,
   input  logic [7:0]          req_blue_in,
   output logic [7:0]          rsp_red_out,
   output logic [7:0]          rsp_green_out,
   output logic [7:0]          rsp_blue_out,
   output logic                rsp_ripple_active
);

   logic [11:0] pulse_ff;
   logic [7:0]  width_ff;
   logic [8:0]  size_ff;

   prb_pkg::op_type op_ff;
   logic [7:0]  idx_ff, r_in_ff, g_in_ff, b_in_ff;

   logic [11:0] frame_ff;
   logic [7:0]  col_r_ff, col_g_ff, col_b_ff;

   logic [23:0] mem [prb_pkg::PALETTE_DEPTH];
   logic [prb_pkg::PALETTE_DEPTH-1:0] valid_ff;
   logic [23:0] rd_data_ff;
   logic        rd_ok_ff;
   logic [23:0] rd_pix;
   logic        in_range;
   logic        wr_en, rd_en;
   logic [prb_pkg::PAL_AW-1:0] wr_addr, rd_addr;
   logic [23:0] wr_data;

   logic [9:0]  reach;
   logic [21:0] prod_ff;
   logic [11:0] prem_ff;
   logic [9:0]  pq_ff;
   logic [12:0] ptrial;
   logic        pfits;

   logic signed [11:0] pos, pos_end, rise, stop, span, fall, limit;
   logic [8:0]  rise_ff, stop_ff, fall_ff, j_ff;

   logic [6:0]  mid;
   logic        first_half;
   logic [8:0]  offs;
   logic signed [9:0] kpos;
   logic [7:0]  a_val, b_val, d_val;
   logic [7:0]  coef_a_ff, coef_b_ff, coef_d_ff;
   logic [15:0] num_r, num_g, num_b;
   logic [7:0]  q_r, q_g, q_b;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= 12'd60;
         width_ff <= 8'd32;
         size_ff  <= 9'd256;
      end else if (csr_write_en) begin
         unique case (csr_index)
            prb_pkg::CSR_PULSE_FRAMES: pulse_ff <= csr_wdata;
            prb_pkg::CSR_RIPPLE_WIDTH: width_ff <= csr_wdata[7:0];
            prb_pkg::CSR_PALETTE_SIZE: size_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Captured request beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= prb_pkg::op_type'(req_operation);
         idx_ff  <= req_entry_index;
         r_in_ff <= req_red_in;
         g_in_ff <= req_green_in;
         b_in_ff <= req_blue_in;
      end
   end

   // Ripple colour and frame counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         col_r_ff <= '0;
         col_g_ff <= '0;
         col_b_ff <= '0;
      end else if (cmd.start_apply) begin
         frame_ff <= 12'd1;
         col_r_ff <= r_in_ff;
         col_g_ff <= g_in_ff;
         col_b_ff <= b_in_ff;
      end else if (cmd.frame_clear) begin
         frame_ff <= '0;
      end else if (cmd.frame_adv) begin
         frame_ff <= frame_ff + 12'd1;
      end
   end

   // Palette memory: one write and one registered read port; an entry never
   // written since reset reads as zero through its valid bit.
   assign in_range = {1'b0, idx_ff} < 9'(prb_pkg::PALETTE_DEPTH);
   assign wr_en    = (cmd.mem_write && in_range) || cmd.ent_write;
   assign wr_addr  = cmd.mem_write ? idx_ff[prb_pkg::PAL_AW-1:0] : j_ff[prb_pkg::PAL_AW-1:0];
   assign wr_data  = cmd.mem_write ? {r_in_ff, g_in_ff, b_in_ff} : {q_r, q_g, q_b};
   assign rd_en    = cmd.mem_read || cmd.ent_read;
   assign rd_addr  = cmd.mem_read ? idx_ff[prb_pkg::PAL_AW-1:0] : j_ff[prb_pkg::PAL_AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= valid_ff[rd_addr] && (in_range || !cmd.mem_read);
         end
      end
   end

   assign rd_pix = rd_ok_ff ? rd_data_ff : '0;

   // Window position: product, then a ten step division by the pulse length.
   assign reach  = 10'(size_ff) + {1'b0, width_ff, 1'b0};
   assign ptrial = {prem_ff, pq_ff[9]};
   assign pfits  = ptrial >= {1'b0, pulse_ff};

   always_ff @(posedge clock) begin
      if (cmd.pos_mul) begin
         prod_ff <= 22'(reach) * 22'(frame_ff);
      end
      if (cmd.pos_load) begin
         prem_ff <= prod_ff[21:10];
         pq_ff   <= prod_ff[9:0];
      end else if (cmd.pos_step) begin
         prem_ff <= pfits ? 12'(ptrial - {1'b0, pulse_ff}) : ptrial[11:0];
         pq_ff   <= {pq_ff[8:0], pfits};
      end
   end

   always_comb begin
      pos     = $signed({2'b00, pq_ff}) - $signed({4'b0000, width_ff});
      pos_end = pos + $signed({4'b0000, width_ff});
      rise    = (pos > 12'sd0) ? pos : 12'sd0;
      limit   = (size_ff < 9'(prb_pkg::WINDOW_CAP)) ? $signed({3'b000, size_ff})
                                                     : 12'sd0 + 12'(prb_pkg::WINDOW_CAP);
      stop    = (pos_end < limit) ? pos_end : limit;
      span    = stop - rise;
      fall    = rise + (span >>> 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.win_setup) begin
         rise_ff <= rise[8:0];
         stop_ff <= stop[8:0];
         fall_ff <= fall[8:0];
         j_ff    <= rise[8:0];
      end else if (cmd.ent_skip || cmd.ent_write) begin
         j_ff <= j_ff + 9'd1;
      end
   end

   // Blend weights of the entry at j.
   always_comb begin
      mid        = width_ff[7:1];
      first_half = j_ff < fall_ff;
      offs       = j_ff - rise_ff;
      kpos       = $signed({2'b00, width_ff}) - $signed({1'b0, stop_ff})
                 + $signed({1'b0, j_ff});
      if (first_half) begin
         a_val = {1'b0, mid} - {1'b0, offs[6:0]};
         b_val = offs[7:0];
         d_val = {1'b0, mid};
      end else begin
         a_val = kpos[7:0] - {1'b0, mid};
         b_val = width_ff - kpos[7:0];
         d_val = width_ff - {1'b0, mid};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ent_read) begin
         coef_a_ff <= a_val;
         coef_b_ff <= b_val;
         coef_d_ff <= d_val;
      end
   end

   assign num_r = rd_pix[23:16] * coef_a_ff + col_r_ff * coef_b_ff;
   assign num_g = rd_pix[15:8]  * coef_a_ff + col_g_ff * coef_b_ff;
   assign num_b = rd_pix[7:0]   * coef_a_ff + col_b_ff * coef_b_ff;

   prb_lane u_lane_r (
      .clock (clock),
      .load  (cmd.lane_load),
      .step  (cmd.lane_step),
      .num   (num_r[14:0]),
      .den   (coef_d_ff),
      .quot  (q_r)
   );

   prb_lane u_lane_g (
      .clock (clock),
      .load  (cmd.lane_load),
      .step  (cmd.lane_step),
      .num   (num_g[14:0]),
      .den   (coef_d_ff),
      .quot  (q_g)
   );

   prb_lane u_lane_b (
      .clock (clock),
      .load  (cmd.lane_load),
      .step  (cmd.lane_step),
      .num   (num_b[14:0]),
      .den   (coef_d_ff),
      .quot  (q_b)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            prb_pkg::OUT_READ: begin
               rsp_red_out       <= rd_pix[23:16];
               rsp_green_out     <= rd_pix[15:8];
               rsp_blue_out      <= rd_pix[7:0];
               rsp_ripple_active <= 1'b0;
            end
            prb_pkg::OUT_ACTIVE: begin
               rsp_red_out       <= '0;
               rsp_green_out     <= '0;
               rsp_blue_out      <= '0;
               rsp_ripple_active <= 1'b1;
            end
            default: begin
               rsp_red_out       <= '0;
               rsp_green_out     <= '0;
               rsp_blue_out      <= '0;
               rsp_ripple_active <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.frame_idle = frame_ff == 12'd0;
      sts.frame_last = frame_ff >= pulse_ff;
      sts.pos_over   = pos > 12'sd255;
      sts.walk_done  = j_ff >= stop_ff;
      sts.ent_skip   = first_half ? (mid == 7'd0)
                                  : ((kpos < $signed({3'b000, mid})) || (width_ff == 8'd0));
   end

endmodule

// ===== sv/prb_ctrl.sv =====
// Controller state machine that sequences each request beat through the datapath.
`timescale 1ns / 1ps
`include "palette_ripple_blender_top_assert.svh"

module prb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  prb_pkg::sts_type sts,
   output prb_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_POS_LOAD,
      S_POS_DIV,
      S_POS_CHK,
      S_WALK,
      S_LOAD,
      S_DIV,
      S_WRITE,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [prb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   prb_pkg::out_sel_type sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.out_sel  = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            sel_in   = prb_pkg::OUT_ZERO;
            state_in = S_OUT;
            unique case (sts.op)
               prb_pkg::OP_WRITE: cmd.mem_write = 1'b1;
               prb_pkg::OP_READ: begin
                  cmd.mem_read = 1'b1;
                  sel_in       = prb_pkg::OUT_READ;
               end
               prb_pkg::OP_START: cmd.start_apply = 1'b1;
               default: begin
                  if (sts.frame_idle) begin
                     state_in = S_OUT;
                  end else if (sts.frame_last) begin
                     cmd.frame_clear = 1'b1;
                  end else begin
                     cmd.pos_mul = 1'b1;
                     state_in    = S_POS_LOAD;
                  end
               end
            endcase
         end
         S_POS_LOAD: begin
            cmd.pos_load = 1'b1;
            cnt_in       = prb_pkg::CNT_W'(prb_pkg::POS_QBITS);
            state_in     = S_POS_DIV;
         end
         S_POS_DIV: begin
            cmd.pos_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == prb_pkg::CNT_W'(1)) begin
               state_in = S_POS_CHK;
            end
         end
         S_POS_CHK: begin
            if (sts.pos_over) begin
               state_in = S_OUT;
            end else begin
               cmd.win_setup = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.walk_done) begin
               cmd.frame_adv = 1'b1;
               sel_in        = prb_pkg::OUT_ACTIVE;
               state_in      = S_OUT;
            end else if (sts.ent_skip) begin
               cmd.ent_skip = 1'b1;
            end else begin
               cmd.ent_read = 1'b1;
               state_in     = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.lane_load = 1'b1;
            cnt_in        = prb_pkg::CNT_W'(prb_pkg::LANE_QBITS);
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.lane_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == prb_pkg::CNT_W'(1)) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.ent_write = 1'b1;
            state_in      = S_WALK;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= prb_pkg::OUT_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `PRB_ASSERT_NOW(a_step_count, clock, reset, cmd.pos_step || cmd.lane_step, cnt_ff != '0)
   `PRB_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, out_free)
   `PRB_ASSERT_NEXT(a_accept_dispatch, clock, reset, cmd.capture, state_ff == S_DISPATCH)

endmodule

// ===== sv/palette_ripple_blender_top.sv =====
// Top level of the palette ripple blender: controller and datapath.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// req       req_valid / req_ready   req_operation, req_entry_index, req_red_in, ..
// rsp       rsp_valid / rsp_ready   rsp_red_out, rsp_green_out, rsp_blue_out, ..
// csr       csr_write_en            csr_index, csr_wdata
//
// Write, read and start beats pass from acceptance through the dispatch and
// output states; a new beat is taken only once the block is back in idle.
// A tick blends its window entries one after another, skipping those of no weight:
// each blended entry is one memory read, a load, eight steps of the channel dividers
// and one write; the window position needs ten steps of its own divider.
// Reset is synchronous and clears the palette at once through per-entry valid bits.
// A stalled result holds only the result register; the block still takes the
// next beat and stalls only when that beat's result is ready to be shown.

module palette_ripple_blender_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_ripple_active
);

   // Commands flow from the controller; status flows back from the datapath.
   prb_pkg::cmd_type cmd;
   prb_pkg::sts_type sts;

   prb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   prb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_ripple_active (rsp_ripple_active)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the palette ripple blender.
`timescale 1ns / 1ps

module tb;

   localparam int  LIMIT_CYCLES = 2000000;
   localparam int  MAX_REPORTS  = 10;
   localparam int  HOLD_CYCLES  = 400;
   localparam int  DRAIN_CYCLES = 60;

   // A result beat as the checker sees it.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       active;
   } colour_result_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [11:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [7:0]  req_entry_index;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_ripple_active;

   palette_ripple_blender_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_ripple_active (rsp_ripple_active)
   );

   // Predicted copy of the block's registers and state.
   logic [11:0] pulse_frames_q;
   logic [7:0]  ripple_width_q;
   logic [8:0]  palette_size_q;
   logic [11:0] frame_q;
   logic [7:0]  tint_r, tint_g, tint_b;
   logic [7:0]  shade_r [prb_pkg::PALETTE_DEPTH];
   logic [7:0]  shade_g [prb_pkg::PALETTE_DEPTH];
   logic [7:0]  shade_b [prb_pkg::PALETTE_DEPTH];

   colour_result_type pending_colours[$];
   int  mismatch_count;
   int  cycle_count;
   bit  quiet_sides;     // when set, neither side idles
   bit  hold_request;    // asks the receiver for one long hold-off

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Blends the colour into one entry with weights a and b over divisor d.
   function automatic logic [7:0] mix_channel(logic [7:0] old_v, logic [7:0] tint_v,
                                              int unsigned a, int unsigned b,
                                              int unsigned d);
      int unsigned sum;
      sum = int'(old_v) * a + int'(tint_v) * b;
      return 8'(sum / d);
   endfunction

   // Applies one frame of the ripple and returns whether a frame was applied.
   function automatic logic advance_ripple();
      int pulse, w, now, pos, mid, rise, lim, stop, span, fall, i, j, k;
      pulse = int'(pulse_frames_q);
      w     = int'(ripple_width_q);
      now   = int'(frame_q);
      if (now == 0)
         return 1'b0;
      if (now >= pulse) begin
         frame_q = '0;
         return 1'b0;
      end
      pos = ((int'(palette_size_q) + 2 * w) * now) / pulse - w;
      // A window pushed past the palette stalls the ripple without advancing.
      if (pos > 255)
         return 1'b0;
      mid  = w / 2;
      rise = (pos > 0) ? pos : 0;
      lim  = int'(palette_size_q);
      if (lim > prb_pkg::WINDOW_CAP)
         lim = prb_pkg::WINDOW_CAP;
      stop = (pos + w < lim) ? pos + w : lim;
      span = stop - rise;
      if (span > 0) begin
         fall = rise + span / 2;
         i = 0;
         for (j = rise; j < fall && mid > 0; j++) begin
            shade_r[j] = mix_channel(shade_r[j], tint_r, mid - i, i, mid);
            shade_g[j] = mix_channel(shade_g[j], tint_g, mid - i, i, mid);
            shade_b[j] = mix_channel(shade_b[j], tint_b, mid - i, i, mid);
            i++;
         end
         for (j = fall; j < stop; j++) begin
            k = w - (stop - j);
            if (k >= mid && w - mid > 0) begin
               shade_r[j] = mix_channel(shade_r[j], tint_r, k - mid, w - k, w - mid);
               shade_g[j] = mix_channel(shade_g[j], tint_g, k - mid, w - k, w - mid);
               shade_b[j] = mix_channel(shade_b[j], tint_b, k - mid, w - k, w - mid);
            end
         end
      end
      frame_q = 12'(now + 1);
      return 1'b1;
   endfunction

   function automatic colour_result_type predict_colour(prb_pkg::op_type op,
                                                        logic [7:0] idx,
                                                        logic [7:0] r, logic [7:0] g,
                                                        logic [7:0] b);
      colour_result_type res;
      res = '0;
      case (op)
         prb_pkg::OP_WRITE: begin
            shade_r[idx] = r;
            shade_g[idx] = g;
            shade_b[idx] = b;
         end
         prb_pkg::OP_READ: begin
            res.red   = shade_r[idx];
            res.green = shade_g[idx];
            res.blue  = shade_b[idx];
         end
         prb_pkg::OP_START: begin
            tint_r  = r;
            tint_g  = g;
            tint_b  = b;
            frame_q = 12'd1;
         end
         default: res.active = advance_ripple();
      endcase
      return res;
   endfunction

   function automatic int draw_idle();
      return quiet_sides ? 0 : $urandom_range(0, 14);
   endfunction

   // Offers one beat, starting at a falling edge and returning at one.
   // Valid is left high so that back-to-back beats need no second assignment.
   task automatic send_beat(prb_pkg::op_type op, logic [7:0] idx, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_colours.push_back(predict_colour(op, idx, r, g, b));
      @(negedge clock);
   endtask

   task automatic send_random_colour(prb_pkg::op_type op, logic [7:0] idx);
      send_beat(op, idx, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Waits until every expected result is back and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_colours.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [11:0] value);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         prb_pkg::CSR_PULSE_FRAMES: pulse_frames_q = value;
         prb_pkg::CSR_RIPPLE_WIDTH: ripple_width_q = value[7:0];
         default:                   palette_size_q = value[8:0];
      endcase
   endtask

   task automatic set_ripple(int pulse, int width, int size);
      write_csr(prb_pkg::CSR_PULSE_FRAMES, 12'(pulse));
      write_csr(prb_pkg::CSR_RIPPLE_WIDTH, 12'(width));
      write_csr(prb_pkg::CSR_PALETTE_SIZE, 12'(size));
   endtask

   // Receiver: stalls at random, and once holds off long enough to back up the block.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            stall = draw_idle();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         @(negedge clock);
      end
   end

   // Result checker: each beat against the oldest expectation.
   always @(posedge clock) begin
      colour_result_type want;
      colour_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_ripple_active};
         if (pending_colours.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat %h", got);
         end else begin
            want = pending_colours.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.active !== want.active) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result mismatch: expected rgb %h %h %h active %b, got %h %h %h %b",
                           want.red, want.green, want.blue, want.active,
                           got.red, got.green, got.blue, got.active);
            end
         end
      end
   end

   // Extreme entries and colours, every operation, idle and last-frame ticks.
   task automatic test_directed();
      send_beat(prb_pkg::OP_READ, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_beat(prb_pkg::OP_WRITE, 8'd255, 8'hAA, 8'h55, 8'h0F);
      send_beat(prb_pkg::OP_WRITE, 8'd127, 8'h55, 8'hAA, 8'hF0);
      send_beat(prb_pkg::OP_READ, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_beat(prb_pkg::OP_READ, 8'd255, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_READ, 8'd127, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_READ, 8'd128, 8'h00, 8'h00, 8'h00);
      for (int e = 0; e < 40; e += 3)
         send_random_colour(prb_pkg::OP_WRITE, 8'(e));
      set_ripple(3, 32, 256);
      send_beat(prb_pkg::OP_START, 8'd0, 8'hFF, 8'h80, 8'h00);
      repeat (4) send_beat(prb_pkg::OP_TICK, 8'hFF, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_READ, 8'd10, 8'h00, 8'h00, 8'h00);
   endtask

   // Register extremes: single frame, longest pulse, zero and full width, small palettes.
   task automatic test_settings();
      set_ripple(1, 255, 0);
      send_beat(prb_pkg::OP_START, 8'd0, 8'h12, 8'h34, 8'h56);
      send_beat(prb_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
      set_ripple(4095, 0, 256);
      send_beat(prb_pkg::OP_START, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      repeat (2) send_beat(prb_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
      set_ripple(5, 1, 16);
      send_beat(prb_pkg::OP_START, 8'd0, 8'h00, 8'hFF, 8'h00);
      repeat (3) send_beat(prb_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
      // Full width over the whole palette; the third frame pushes the window
      // past the end, so the ripple stalls until the next start.
      set_ripple(4, 255, 256);
      send_beat(prb_pkg::OP_START, 8'd0, 8'h80, 8'h40, 8'hC0);
      repeat (5) send_beat(prb_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_READ, 8'd100, 8'h00, 8'h00, 8'h00);
      set_ripple(6, 40, 64);
      send_beat(prb_pkg::OP_START, 8'd0, 8'h0F, 8'hF0, 8'h3C);
      repeat (7) send_beat(prb_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(prb_pkg::OP_READ, 8'd30, 8'h00, 8'h00, 8'h00);
   endtask

   // Whole ripples with random content, with stray beats and early restarts.
   task automatic test_random_ripples();
      int ticks;
      int choice;
      for (int phase = 0; phase < 5; phase++) begin
         quiet_sides = (phase == 4);
         set_ripple($urandom_range(1, 10), $urandom_range(0, 255), $urandom_range(0, 256));
         repeat (3) send_random_colour(prb_pkg::OP_WRITE, 8'($urandom));
         send_random_colour(prb_pkg::OP_START, 8'($urandom));
         ticks = int'(pulse_frames_q) + 1;
         for (int t = 0; t < ticks; t++) begin
            choice = $urandom_range(0, 9);
            if (choice == 0)
               send_random_colour(prb_pkg::OP_READ, 8'($urandom));
            else if (choice == 1)
               send_random_colour(prb_pkg::OP_WRITE, 8'($urandom));
            else if (choice == 2 && phase % 3 == 2)
               send_random_colour(prb_pkg::OP_START, 8'($urandom));
            send_random_colour(prb_pkg::OP_TICK, 8'($urandom));
         end
         repeat (2) send_random_colour(prb_pkg::OP_READ, 8'($urandom_range(0, 80)));
      end
      quiet_sides = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering beats.
   task automatic test_backpressure();
      prb_pkg::op_type op;
      wait_idle();
      hold_request = 1'b1;
      quiet_sides  = 1'b1;
      for (int n = 0; n < 12; n++) begin
         op = (n % 2 != 0) ? prb_pkg::OP_READ : prb_pkg::OP_WRITE;
         send_random_colour(op, 8'($urandom_range(0, 15)));
      end
      quiet_sides = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = prb_pkg::CSR_PULSE_FRAMES;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_operation   = prb_pkg::OP_WRITE;
      req_entry_index = '0;
      req_red_in      = '0;
      req_green_in    = '0;
      req_blue_in     = '0;
      mismatch_count  = 0;
      cycle_count     = 0;
      quiet_sides     = 1'b0;
      hold_request    = 1'b0;
      pulse_frames_q  = 12'd60;
      ripple_width_q  = 8'd32;
      palette_size_q  = 9'd256;
      frame_q         = '0;
      tint_r          = '0;
      tint_g          = '0;
      tint_b          = '0;
      for (int e = 0; e < prb_pkg::PALETTE_DEPTH; e++) begin
         shade_r[e] = '0;
         shade_g[e] = '0;
         shade_b[e] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_settings();
      test_random_ripples();
      // Leave the reset defaults on the way out so that they get one more ripple.
      set_ripple(60, 32, 256);
      send_random_colour(prb_pkg::OP_START, 8'd0);
      repeat (3) send_random_colour(prb_pkg::OP_TICK, 8'd0);

      wait_idle();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
